// ----- sv/dlr_pkg.sv -----
// ----------------------------------------------------------------------------
// dlr_pkg
// shared types and codes of the dda line rasteriser
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SQUARE    = 6'b000010,
        ST_SUM       = 6'b000100,
        ST_ROOT      = 6'b001000,
        ST_DIV       = 6'b010000,
        ST_FRAC_ROOT = 6'b100000
    } state_t;

endpackage

// ----- sv/dda_line_raster.sv -----
// ----------------------------------------------------------------------------
// dda_line_raster
// fixed-point dda line rasteriser with bit-serial set-up arithmetic
// ----------------------------------------------------------------------------
// input items arrive on s_axis: tuser is the mode, tdata the two end points.
// a load item sets up a new line and gives no output item. set-up runs
// through a bit-serial square root and a bit-serial divider, one result bit
// per cycle, with a root of RT_W = max(COORD_BITS+4, FRAC_BITS) bits.
// it squares, sums, roots, then divides and roots once per axis.
// a zero-length line goes back to idle from the sum step, skipping the rest.
// s_axis_tready stays low for the whole set-up.
// a tick item while steps remain moves the position one step and gives one
// pixel on m_axis in the cycle after; tlast marks the final step. ticks are
// taken one per cycle while m_axis_tready is high: one pixel per cycle.
// a tick with no steps left is taken and dropped.
// the output register holds a pixel while m_axis_tready is low; a new item
// is only taken when that register is empty or being emptied.
// after reset the block is idle with no line loaded.
// ----------------------------------------------------------------------------
module dda_line_raster #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // mode
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                   m_axis_tlast
);

    localparam int C         = COORD_BITS;
    localparam int F         = FRAC_BITS;
    localparam int M_DATA_W  = ((2*C+7)/8)*8;
    localparam int DV_W      = 2*C + 8;
    localparam int QUO_W     = 2*F;
    localparam int SQ_W      = (DV_W > QUO_W) ? DV_W : QUO_W;
    localparam int RT_W      = SQ_W / 2;
    localparam int SQ_REM_W  = RT_W + 2;
    localparam int SQ_SH_W   = RT_W + 4;
    localparam int STEP_W    = C + 4;
    localparam int INC_W     = F + 2;
    localparam int POS_W     = C + F + 2;
    localparam int CNT_MAX   = (RT_W > QUO_W) ? RT_W : QUO_W;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);

    dlr_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic axis_reg, axis_next;

    logic [C-1:0] adx_reg, adx_next, ady_reg, ady_next;
    logic negx_reg, negx_next, negy_reg, negy_next;
    logic [2*C-1:0] d2x_reg, d2x_next, d2y_reg, d2y_next;
    logic [DV_W-1:0] s100_reg, s100_next;

    logic [SQ_W-1:0] sq_rad_reg, sq_rad_next;
    logic [SQ_REM_W-1:0] sq_rem_reg, sq_rem_next;
    logic [RT_W-1:0] sq_root_reg, sq_root_next;
    logic [DV_W-1:0] dv_rem_reg, dv_rem_next;
    logic [QUO_W-1:0] dv_quo_reg, dv_quo_next;

    logic signed [POS_W-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [INC_W-1:0] inc_x_reg, inc_x_next, inc_y_reg, inc_y_next;
    logic [STEP_W-1:0] steps_left_reg, steps_left_next;

    logic m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic m_last_reg, m_last_next;

    logic s_fire, load_fire, tick_fire;
    logic [C-1:0] sx, sy, ex, ey;
    logic [C:0] dxs, dys;
    logic [2*C:0] l2;

    logic [SQ_SH_W-1:0] sq_shift, sq_trial;
    logic sq_take;
    logic [SQ_REM_W-1:0] sq_rem_new;
    logic [RT_W-1:0] sq_root_new;

    logic [DV_W:0] dv_shift, dv_div;
    logic dv_take;
    logic [DV_W-1:0] dv_rem_new;
    logic [QUO_W-1:0] dv_quo_new;

    logic signed [INC_W-1:0] inc_mag;
    logic signed [POS_W-1:0] pos_x_sum, pos_y_sum;
    logic [C-1:0] pix_x, pix_y;

    assign sx = s_axis_tdata[C-1:0];
    assign sy = s_axis_tdata[2*C-1:C];
    assign ex = s_axis_tdata[3*C-1:2*C];
    assign ey = s_axis_tdata[4*C-1:3*C];

    assign s_axis_tready = (state_reg == dlr_pkg::ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign load_fire     = s_fire && (s_axis_tuser == dlr_pkg::MODE_LOAD);
    assign tick_fire     = s_fire && (s_axis_tuser == dlr_pkg::MODE_TICK)
                           && (steps_left_reg != '0);

    assign dxs = {1'b0, ex} - {1'b0, sx};
    assign dys = {1'b0, ey} - {1'b0, sy};
    assign l2  = {1'b0, d2x_reg} + {1'b0, d2y_reg};

    // square root, one result bit per cycle
    assign sq_shift    = {sq_rem_reg, sq_rad_reg[SQ_W-1 -: 2]};
    assign sq_trial    = {2'b00, sq_root_reg, 2'b01};
    assign sq_take     = sq_shift >= sq_trial;
    assign sq_rem_new  = sq_take ? SQ_REM_W'(sq_shift - sq_trial) : SQ_REM_W'(sq_shift);
    assign sq_root_new = {sq_root_reg[RT_W-2:0], sq_take};

    // restoring divider, one quotient bit per cycle
    assign dv_shift   = {dv_rem_reg, 1'b0};
    assign dv_div     = {1'b0, s100_reg};
    assign dv_take    = dv_shift >= dv_div;
    assign dv_rem_new = dv_take ? DV_W'(dv_shift - dv_div) : DV_W'(dv_shift);
    assign dv_quo_new = {dv_quo_reg[QUO_W-2:0], dv_take};

    assign inc_mag   = INC_W'(sq_root_new);
    assign pos_x_sum = pos_x_reg + POS_W'(inc_x_reg);
    assign pos_y_sum = pos_y_reg + POS_W'(inc_y_reg);

    always_comb
    begin
        pix_x = pos_x_sum[POS_W-2:F+C] != '0 ? '1 : pos_x_sum[F+C-1:F];
        if (pos_x_sum[POS_W-1])
        begin
            pix_x = '0;
        end
        pix_y = pos_y_sum[POS_W-2:F+C] != '0 ? '1 : pos_y_sum[F+C-1:F];
        if (pos_y_sum[POS_W-1])
        begin
            pix_y = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        axis_next       = axis_reg;
        adx_next        = adx_reg;
        ady_next        = ady_reg;
        negx_next       = negx_reg;
        negy_next       = negy_reg;
        d2x_next        = d2x_reg;
        d2y_next        = d2y_reg;
        s100_next       = s100_reg;
        sq_rad_next     = sq_rad_reg;
        sq_rem_next     = sq_rem_reg;
        sq_root_next    = sq_root_reg;
        dv_rem_next     = dv_rem_reg;
        dv_quo_next     = dv_quo_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        steps_left_next = steps_left_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        unique case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                if (load_fire)
                begin
                    negx_next       = dxs[C];
                    negy_next       = dys[C];
                    adx_next        = dxs[C] ? C'(-dxs) : dxs[C-1:0];
                    ady_next        = dys[C] ? C'(-dys) : dys[C-1:0];
                    pos_x_next      = POS_W'(sx) <<< F;
                    pos_y_next      = POS_W'(sy) <<< F;
                    inc_x_next      = '0;
                    inc_y_next      = '0;
                    steps_left_next = '0;
                    state_next      = dlr_pkg::ST_SQUARE;
                end
                else if (tick_fire)
                begin
                    pos_x_next      = pos_x_sum;
                    pos_y_next      = pos_y_sum;
                    steps_left_next = steps_left_reg - STEP_W'(1);
                    m_valid_next    = 1'b1;
                    m_data_next     = M_DATA_W'({pix_y, pix_x});
                    m_last_next     = steps_left_reg == STEP_W'(1);
                end
            end
            dlr_pkg::ST_SQUARE:
            begin
                d2x_next   = adx_reg * adx_reg;
                d2y_next   = ady_reg * ady_reg;
                state_next = dlr_pkg::ST_SUM;
            end
            dlr_pkg::ST_SUM:
            begin
                // times 100 as 64 + 32 + 4
                s100_next    = (DV_W'(l2) << 6) + (DV_W'(l2) << 5) + (DV_W'(l2) << 2);
                sq_rad_next  = SQ_W'((DV_W'(l2) << 6) + (DV_W'(l2) << 5) + (DV_W'(l2) << 2));
                sq_rem_next  = '0;
                sq_root_next = '0;
                cnt_next     = CNT_W'(RT_W);
                state_next   = (l2 == '0) ? dlr_pkg::ST_IDLE : dlr_pkg::ST_ROOT;
            end
            dlr_pkg::ST_ROOT:
            begin
                sq_rad_next  = sq_rad_reg << 2;
                sq_rem_next  = sq_rem_new;
                sq_root_next = sq_root_new;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    // round the step count up
                    steps_left_next = STEP_W'(sq_root_new) + STEP_W'(sq_rem_new != '0);
                    dv_rem_next     = DV_W'(d2x_reg);
                    dv_quo_next     = '0;
                    axis_next       = 1'b0;
                    cnt_next        = CNT_W'(QUO_W);
                    state_next      = dlr_pkg::ST_DIV;
                end
            end
            dlr_pkg::ST_DIV:
            begin
                dv_rem_next = dv_rem_new;
                dv_quo_next = dv_quo_new;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    sq_rad_next  = SQ_W'(dv_quo_new);
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = CNT_W'(RT_W);
                    state_next   = dlr_pkg::ST_FRAC_ROOT;
                end
            end
            dlr_pkg::ST_FRAC_ROOT:
            begin
                sq_rad_next  = sq_rad_reg << 2;
                sq_rem_next  = sq_rem_new;
                sq_root_next = sq_root_new;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    if (!axis_reg)
                    begin
                        inc_x_next  = negx_reg ? -inc_mag : inc_mag;
                        dv_rem_next = DV_W'(d2y_reg);
                        dv_quo_next = '0;
                        axis_next   = 1'b1;
                        cnt_next    = CNT_W'(QUO_W);
                        state_next  = dlr_pkg::ST_DIV;
                    end
                    else
                    begin
                        inc_y_next = negy_reg ? -inc_mag : inc_mag;
                        state_next = dlr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dlr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dlr_pkg::ST_IDLE;
            cnt_reg        <= '0;
            axis_reg       <= 1'b0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            inc_x_reg      <= '0;
            inc_y_reg      <= '0;
            steps_left_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            axis_reg       <= axis_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            inc_x_reg      <= inc_x_next;
            inc_y_reg      <= inc_y_next;
            steps_left_reg <= steps_left_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg     <= adx_next;
        ady_reg     <= ady_next;
        negx_reg    <= negx_next;
        negy_reg    <= negy_next;
        d2x_reg     <= d2x_next;
        d2y_reg     <= d2y_next;
        s100_reg    <= s100_next;
        sq_rad_reg  <= sq_rad_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        dv_rem_reg  <= dv_rem_next;
        dv_quo_reg  <= dv_quo_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ----- sv/dlr_checker.sv -----
// ----------------------------------------------------------------------------
// dlr_checker
// port-level checks of the dda line rasteriser
// ----------------------------------------------------------------------------
module dlr_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    // mode
    input logic                                   s_axis_tuser,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    // pixel_x, pixel_y
    input logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    input logic                                   m_axis_tlast
);

    logic load_fire;

    assign load_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser == dlr_pkg::MODE_LOAD);

    // output item holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // set-up starts after a load, so input is held off
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> !s_axis_tready)
        else $error("input ready right after a load item");

    // a load item makes no pixel
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire && !(m_axis_tvalid && !m_axis_tready) |=> !m_axis_tvalid)
        else $error("pixel produced by a load item");

    // input only taken when a pending pixel is leaving
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input ready while output stalled");

endmodule

bind dda_line_raster dlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_dlr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dda line rasteriser
// ----------------------------------------------------------------------------
// line loads and step ticks are queued per phase and driven on s_axis. every
// accepted item runs through a fixed-point model of the walk kept here. the
// pixels it predicts are checked in order against m_axis. phases vary the
// idle and stall rates, and one phase holds the output off for a long
// stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int CLK_HALF   = 10;
    localparam int LOAD_LAT   = 130;

    typedef struct packed {
        logic       mode;
        logic [9:0] start_x;
        logic [9:0] start_y;
        logic [9:0] end_x;
        logic [9:0] end_y;
    } line_cmd_t;

    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
        logic       last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    line_cmd_t cmd_queue[$];
    pixel_t    pixels_due[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_target = 0;
    int hold_done = 0;
    bit item_taken = 1'b0;
    int fail_count = 0;

    int loads_seen = 0;
    int ticks_seen = 0;
    int pixels_checked = 0;
    int lines_finished = 0;

    longint walk_x = 0;
    longint walk_y = 0;
    longint step_x = 0;
    longint step_y = 0;
    int     steps_left = 0;

    dda_line_raster #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic longint unsigned root_ceil(longint unsigned n);
        longint unsigned r;
        longint unsigned c;
        int b;
        r = 0;
        for (b = 20; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= n)
                r = c;
        end
        if (r * r < n)
            r++;
        return r;
    endfunction

    // largest q with q*q*s100 <= d*d * 2^(2*frac), signed like d
    function automatic longint step_size(longint d, longint unsigned s100);
        longint unsigned mag;
        longint unsigned q;
        longint unsigned c;
        bit [127:0] rhs;
        int b;
        mag = (d < 0) ? -d : d;
        rhs = 128'(mag * mag) << (2 * FRAC_BITS);
        q = 0;
        for (b = FRAC_BITS; b >= 0; b--)
        begin
            c = q | (64'd1 << b);
            if (128'(c * c) * 128'(s100) <= rhs)
                q = c;
        end
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [9:0] pixel_at(longint p);
        longint f;
        if (p < 0)
            return '0;
        f = p >>> FRAC_BITS;
        if (f > (1 << COORD_BITS) - 1)
            return '1;
        return f[9:0];
    endfunction

    function automatic int line_steps(logic [9:0] sx, logic [9:0] sy,
                                      logic [9:0] ex, logic [9:0] ey);
        longint dx;
        longint dy;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        return int'(root_ceil(64'(100 * (dx * dx + dy * dy))));
    endfunction

    task automatic advance_walk(line_cmd_t c);
        longint dx;
        longint dy;
        longint unsigned s100;
        pixel_t px;
        if (c.mode == dlr_pkg::MODE_LOAD)
        begin
            loads_seen++;
            dx = longint'(c.end_x) - longint'(c.start_x);
            dy = longint'(c.end_y) - longint'(c.start_y);
            s100 = 64'(100 * (dx * dx + dy * dy));
            walk_x = longint'(c.start_x) << FRAC_BITS;
            walk_y = longint'(c.start_y) << FRAC_BITS;
            if (s100 == 0)
            begin
                step_x = 0;
                step_y = 0;
                steps_left = 0;
            end
            else
            begin
                step_x = step_size(dx, s100);
                step_y = step_size(dy, s100);
                steps_left = int'(root_ceil(s100));
            end
        end
        else
        begin
            ticks_seen++;
            if (steps_left != 0)
            begin
                walk_x += step_x;
                walk_y += step_y;
                steps_left--;
                px.x = pixel_at(walk_x);
                px.y = pixel_at(walk_y);
                px.last = (steps_left == 0);
                pixels_due.push_back(px);
            end
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n)
        begin
            item_taken = s_axis_tvalid && s_axis_tready;
            if (item_taken)
                advance_walk(line_cmd_t'({s_axis_tuser, s_axis_tdata[9:0],
                    s_axis_tdata[19:10], s_axis_tdata[29:20], s_axis_tdata[39:30]}));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixels_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                             m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tlast);
                end
                else
                begin
                    want = pixels_due.pop_front();
                    pixels_checked++;
                    if (want.last)
                        lines_finished++;
                    if (m_axis_tdata[9:0] !== want.x || m_axis_tdata[19:10] !== want.y
                        || m_axis_tlast !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: pixel mismatch expected x=%0d y=%0d last=%0b",
                                 $time, want.x, want.y, want.last);
                        $display("%0t:                actual   x=%0d y=%0d last=%0b",
                                 $time, m_axis_tdata[9:0], m_axis_tdata[19:10],
                                 m_axis_tlast);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        line_cmd_t c;
        if (rst_n && (!s_axis_tvalid || item_taken))
        begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                c = cmd_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= c.mode;
                s_axis_tdata  <= {c.end_y, c.end_x, c.start_y, c.start_x};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_done < hold_target)
        begin
            hold_done <= hold_done + 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [9:0] pick_coord();
        case ($urandom_range(3))
            0: return 10'($urandom_range(3));
            1: return 10'($urandom_range(1023, 1020));
            default: return 10'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic [9:0] near_coord(logic [9:0] c, int span);
        int v;
        v = int'(c) + $urandom_range(2 * span) - span;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return 10'(v);
    endfunction

    task automatic queue_line(logic [9:0] sx, logic [9:0] sy, logic [9:0] ex,
                              logic [9:0] ey, int ticks);
        line_cmd_t c;
        c = '{dlr_pkg::MODE_LOAD, sx, sy, ex, ey};
        cmd_queue.push_back(c);
        repeat (ticks)
        begin
            c = '{dlr_pkg::MODE_TICK, 10'($urandom), 10'($urandom), 10'($urandom),
                  10'($urandom)};
            cmd_queue.push_back(c);
        end
    endtask

    task automatic queue_random(int budget);
        logic [9:0] sx;
        logic [9:0] sy;
        logic [9:0] ex;
        logic [9:0] ey;
        line_cmd_t c;
        int n;
        int s;
        int sel;
        n = 0;
        while (n < budget)
        begin
            sel = $urandom_range(99);
            sx = pick_coord();
            sy = pick_coord();
            if (sel < 70)
            begin
                ex = near_coord(sx, 5);
                ey = near_coord(sy, 5);
                s = line_steps(sx, sy, ex, ey);
                if (s != 0 && $urandom_range(4) == 0)
                    s = $urandom_range(s, 1);
                else
                    s += $urandom_range(2);
                queue_line(sx, sy, ex, ey, s);
                n += s + 1;
            end
            else if (sel < 78)
            begin
                queue_line(sx, sy, sx, sy, $urandom_range(2, 1));
                n += 1;
            end
            else if (sel < 86)
            begin
                s = $urandom_range(20, 1);
                queue_line(sx, sy, pick_coord(), pick_coord(), s);
                n += s + 1;
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    c = line_cmd_t'(41'({$urandom, $urandom}));
                    cmd_queue.push_back(c);
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_axis_tvalid || pixels_due.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        #1;

        // idle tick, empty line, short line to its end, then cut-off long lines
        queue_line(10'd0, 10'd0, 10'd0, 10'd0, 0);
        cmd_queue.delete();
        cmd_queue.push_back('{dlr_pkg::MODE_TICK, 10'd0, 10'd0, 10'd0, 10'd0});
        queue_line(10'd5, 10'd5, 10'd5, 10'd5, 1);
        queue_line(10'd1023, 10'd0, 10'd1022, 10'd0, 11);
        queue_line(10'd0, 10'd0, 10'd0, 10'd1023, 3);
        queue_line(10'd1023, 10'd1023, 10'd0, 10'd0, 3);
        queue_line(10'd0, 10'd1023, 10'd1023, 10'd0, 1);
        queue_random(230);
        wait_drained();

        send_idle_pct = 58;
        queue_random(180);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 58;
        queue_random(180);
        wait_drained();

        send_idle_pct = 27;
        recv_stall_pct = 27;
        queue_random(180);
        wait_drained();

        // output held off well past the set-up time so the block backs up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_line(10'd100, 10'd100, 10'd104, 10'd103, 50);
        hold_target = hold_done + 400;
        queue_random(110);
        wait_drained();

        repeat (LOAD_LAT) @(posedge clk);
        #1;
        $display("covered %0d loads and %0d ticks, %0d pixels checked over %0d finished lines",
                 loads_seen, ticks_seen, pixels_checked, lines_finished);
        if (pixels_due.size() != 0)
            $display("%0d pixels never arrived", pixels_due.size());
        if (fail_count == 0 && pixels_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("%0t: timeout with %0d pixels outstanding", $time, pixels_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
